[design/dtbs_pkg.sv]
// Shared types and constants for the DBCS trail byte substituter.
// Depends on nothing; dtbs_key_table and the core import it.
package dtbs_pkg;

	// Item opcodes
	typedef enum logic {
		OP_DATA = 1'b0,
		OP_LOAD = 1'b1
	} opcode_t;

	// Trail bytes that send a pair to the table
	localparam logic [7:0] TRAIL_AT    = 8'h40;
	localparam logic [7:0] TRAIL_BRACE = 8'h7D;

	// Lead byte ranges of code page 932
	localparam logic [7:0] LEAD1_LO = 8'h81;
	localparam logic [7:0] LEAD1_HI = 8'h9F;
	localparam logic [7:0] LEAD2_LO = 8'hE0;
	localparam logic [7:0] LEAD2_HI = 8'hFC;

	localparam int DEF_TABLE_ENTRIES = 64;
	localparam int KEY_W             = 16;
	localparam int IDX_IN_W          = 6;

	// Output word queue
	localparam int OUT_DEPTH = 16;
	localparam int OUT_PTR_W = 4;
	localparam int OUT_CNT_W = 5;

	// Words produced by one item
	typedef enum logic [1:0] {
		RUN_NONE   = 2'd0,
		RUN_SINGLE = 2'd1,
		RUN_PAIR   = 2'd2
	} run_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       stream_end;
		logic       was_replaced;
		logic       unmatched;
	} out_word_t;

	function automatic logic is_lead(input logic [7:0] b);
		return ((b >= LEAD1_LO) && (b <= LEAD1_HI)) || ((b >= LEAD2_LO) && (b <= LEAD2_HI));
	endfunction

	function automatic logic is_special_trail(input logic [7:0] b);
		return (b == TRAIL_AT) || (b == TRAIL_BRACE);
	endfunction

endpackage

[design/dtbs_ram.sv]
// Generic single-write, single-read RAM with registered read data (read-first).
// Depends on nothing.
module dtbs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/dtbs_key_table.sv]
// Key store of the substitution table with a parallel compare of every slot.
// Depends on dtbs_pkg.
module dtbs_key_table #(
	parameter int ENTRIES = dtbs_pkg::DEF_TABLE_ENTRIES,
	parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic [IDX_W-1:0]          wr_idx,
	input  logic [dtbs_pkg::KEY_W-1:0] wr_key,
	input  logic [dtbs_pkg::KEY_W-1:0] lookup_key,
	output logic [ENTRIES-1:0]        match
);
	import dtbs_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q [ENTRIES];

	// Valid bits stand in for the reset clear of the key store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q[wr_idx] <= wr_key;
		end
	end

	// A zero key marks an empty slot and never matches
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] != '0) && (key_q[i] == lookup_key);
		end
	end

endmodule

[design/dbcs_trail_byte_substituter_core.sv]
// Top level of the DBCS trail byte substituter.
// Depends on dtbs_pkg, dtbs_key_table and dtbs_ram.
//
// Input channel (in_valid / in_stall): one word per item, either a stream byte
//   (OP_DATA) or a table load (OP_LOAD) into slot entry_index; loads beyond the
//   table size are dropped. Output channel (out_valid / out_stall): one stream
//   byte per word with its flags.
// A lead byte is held until its trail arrives and the pair leaves as two words.
//   Pairs with a trail of 0x40 or 0x7D are looked up: a hit replaces both bytes
//   with the value (high byte first), a miss flags both unmatched.
// Path: after an item is accepted, its first word passes the match register,
//   the value read register and the queue write before it is at the output.
// Throughput: one item per cycle is taken unless in_stall; the output drains
//   one word per cycle unless out_stall; a 16-word output queue absorbs pairs.
// Stall: in_stall rises when the queue could not hold the words of everything
//   in flight plus one more pair; it comes from registers only. A stalled
//   output word holds; the pipeline itself never stops.
// Reset: arst_n clears the pipeline, the held lead byte, the queue and all
//   table slots (empty). No clearing pass is needed.
module dbcs_trail_byte_substituter_core #(
	parameter int TABLE_ENTRIES = dtbs_pkg::DEF_TABLE_ENTRIES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [7:0]                    data_byte,
	input  logic                          stream_last,
	input  logic [dtbs_pkg::IDX_IN_W-1:0] entry_index,
	input  logic [dtbs_pkg::KEY_W-1:0]    entry_key,
	input  logic [dtbs_pkg::KEY_W-1:0]    entry_value,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          run_last,
	output logic                          stream_end,
	output logic                          was_replaced,
	output logic                          unmatched
);
	import dtbs_pkg::*;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// ---------------------------------------------------------------
	// Stage 1: input register
	// ---------------------------------------------------------------
	logic                v_s1;
	opcode_t             op_s1;
	logic [7:0]          byte_s1;
	logic                last_s1;
	logic [IDX_IN_W-1:0] idx_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [KEY_W-1:0]    val_s1;

	logic in_take;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= opcode_t'(opcode);
			byte_s1 <= data_byte;
			last_s1 <= stream_last;
			idx_s1  <= entry_index;
			key_s1  <= entry_key;
			val_s1  <= entry_value;
		end
	end

	// Held lead byte state
	logic       pend_q;
	logic [7:0] held_q;

	// Table load decode
	logic [31:0]      widx_wide;
	logic             load_en;
	logic [IDX_W-1:0] load_idx;

	assign widx_wide = 32'(idx_s1);
	assign load_en   = v_s1 && (op_s1 == OP_LOAD) && (widx_wide < 32'(TABLE_ENTRIES));
	assign load_idx  = widx_wide[IDX_W-1:0];

	// Stream decode
	logic       data_s1;
	run_t       run_c;
	logic [7:0] b0_c;
	logic       lookup_c;

	assign data_s1 = v_s1 && (op_s1 == OP_DATA);

	always_comb begin
		run_c    = RUN_NONE;
		b0_c     = byte_s1;
		lookup_c = 1'b0;
		if (data_s1) begin
			if (pend_q) begin
				run_c    = RUN_PAIR;
				b0_c     = held_q;
				lookup_c = is_special_trail(byte_s1);
			end else if (is_lead(byte_s1) && !last_s1) begin
				run_c = RUN_NONE;
			end else begin
				run_c = RUN_SINGLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			held_q <= '0;
		end else if (data_s1) begin
			if (pend_q) begin
				pend_q <= 1'b0;
				held_q <= '0;
			end else if (is_lead(byte_s1) && !last_s1) begin
				pend_q <= 1'b1;
				held_q <= byte_s1;
			end
		end
	end

	logic [TABLE_ENTRIES-1:0] match_c;

	dtbs_key_table #(
		.ENTRIES (TABLE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_keys (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (load_en),
		.wr_idx     (load_idx),
		.wr_key     (key_s1),
		.lookup_key ({held_q, byte_s1}),
		.match      (match_c)
	);

	// ---------------------------------------------------------------
	// Stage 2: match vector, lowest slot wins
	// ---------------------------------------------------------------
	run_t                     run_s2;
	logic [7:0]               b0_s2;
	logic [7:0]               b1_s2;
	logic                     last_s2;
	logic                     lookup_s2;
	logic [TABLE_ENTRIES-1:0] match_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s2 <= RUN_NONE;
		end else begin
			run_s2 <= run_c;
		end
	end

	always_ff @(posedge clk) begin
		b0_s2     <= b0_c;
		b1_s2     <= byte_s1;
		last_s2   <= last_s1;
		lookup_s2 <= lookup_c;
		match_s2  <= match_c;
	end

	logic [TABLE_ENTRIES-1:0] first_c;
	logic [IDX_W-1:0]         hit_idx_c;

	// Isolate the lowest set bit, then encode it
	assign first_c = match_s2 & (~match_s2 + TABLE_ENTRIES'(1));

	always_comb begin
		hit_idx_c = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (first_c[i]) begin
				hit_idx_c = hit_idx_c | IDX_W'(i);
			end
		end
	end

	logic [KEY_W-1:0] value_s3;

	dtbs_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_ENTRIES),
		.AW    (IDX_W)
	) u_values (
		.clk   (clk),
		.we    (load_en),
		.waddr (load_idx),
		.wdata (val_s1),
		.raddr (hit_idx_c),
		.rdata (value_s3)
	);

	// ---------------------------------------------------------------
	// Stage 3: value read, build output words
	// ---------------------------------------------------------------
	run_t       run_s3;
	logic [7:0] b0_s3;
	logic [7:0] b1_s3;
	logic       last_s3;
	logic       lookup_s3;
	logic       hit_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_s3 <= RUN_NONE;
		end else begin
			run_s3 <= run_s2;
		end
	end

	always_ff @(posedge clk) begin
		b0_s3     <= b0_s2;
		b1_s3     <= b1_s2;
		last_s3   <= last_s2;
		lookup_s3 <= lookup_s2;
		hit_s3    <= lookup_s2 && (|match_s2);
	end

	out_word_t word0_c;
	out_word_t word1_c;

	always_comb begin
		word0_c = '0;
		word1_c = '0;
		if (run_s3 == RUN_SINGLE) begin
			word0_c.out_byte   = b0_s3;
			word0_c.run_last   = 1'b1;
			word0_c.stream_end = last_s3;
		end else begin
			word0_c.out_byte     = hit_s3 ? value_s3[15:8] : b0_s3;
			word0_c.was_replaced = hit_s3;
			word0_c.unmatched    = lookup_s3 && !hit_s3;
		end
		word1_c.out_byte     = hit_s3 ? value_s3[7:0] : b1_s3;
		word1_c.run_last     = 1'b1;
		word1_c.stream_end   = last_s3;
		word1_c.was_replaced = hit_s3;
		word1_c.unmatched    = lookup_s3 && !hit_s3;
	end

	// ---------------------------------------------------------------
	// Output word queue
	// ---------------------------------------------------------------
	out_word_t             oq_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0]  wp_q;
	logic [OUT_PTR_W-1:0]  rp_q;
	logic [OUT_CNT_W-1:0]  used_q;
	logic                  pop;
	logic [OUT_CNT_W-1:0]  push_n;

	assign push_n    = OUT_CNT_W'(run_s3);
	assign out_valid = (used_q != '0);
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (run_s3 != RUN_NONE) begin
			oq_q[wp_q] <= word0_c;
		end
		if (run_s3 == RUN_PAIR) begin
			oq_q[wp_q + OUT_PTR_W'(1)] <= word1_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			used_q <= '0;
		end else begin
			wp_q   <= wp_q + OUT_PTR_W'(run_s3);
			rp_q   <= rp_q + OUT_PTR_W'(pop);
			used_q <= used_q + push_n - OUT_CNT_W'(pop);
		end
	end

	assign out_byte     = oq_q[rp_q].out_byte;
	assign run_last     = oq_q[rp_q].run_last;
	assign stream_end   = oq_q[rp_q].stream_end;
	assign was_replaced = oq_q[rp_q].was_replaced;
	assign unmatched    = oq_q[rp_q].unmatched;

	// Reserve room for every word in flight plus a pair for the next item
	logic [OUT_CNT_W:0] reserve_c;

	assign reserve_c = (OUT_CNT_W + 1)'(used_q)
		+ (OUT_CNT_W + 1)'(run_s2)
		+ (OUT_CNT_W + 1)'(run_s3)
		+ (v_s1 ? (OUT_CNT_W + 1)'(2) : '0)
		+ (OUT_CNT_W + 1)'(2);

	assign in_stall = (reserve_c > (OUT_CNT_W + 1)'(OUT_DEPTH));

endmodule
